/* src/ksat_pkg.sv */
// Package for the keypad scanner core: state and plan encodings, command,
// result kind and key code constants, and the default translation table.
// No dependencies; used by keypad_scan_autorepeat_translate_core.
`default_nettype none

package ksat_pkg;

    // Commands carried by an input beat.
    localparam logic [1:0] CMD_SCAN  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_KEY_EVENT  = 3'd0;
    localparam logic [2:0] KIND_CHAR_BUF   = 3'd1;
    localparam logic [2:0] KIND_CHAR_DROP  = 3'd2;
    localparam logic [2:0] KIND_READ_BYTE  = 3'd3;
    localparam logic [2:0] KIND_READ_EMPTY = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_TABLE_COUNT  = 2'd0;
    localparam logic [1:0] REG_FIRST_DELAY  = 2'd1;
    localparam logic [1:0] REG_REPEAT_DELAY = 2'd2;

    // Input event key codes that get special handling.
    localparam logic [9:0] KC_TAB       = 10'd15;
    localparam logic [9:0] KC_LEFTSHIFT = 10'd42;
    localparam logic [9:0] KC_A         = 10'd30;
    localparam logic [9:0] KC_B         = 10'd48;
    localparam logic [9:0] KC_M         = 10'd50;
    localparam logic [9:0] KC_DOT       = 10'd52;
    localparam logic [9:0] KC_MENU      = 10'd139;

    localparam logic [5:0]  TABLE_COUNT_RST  = 6'd17;
    localparam logic [15:0] FIRST_DELAY_RST  = 16'd20;
    localparam logic [15:0] REPEAT_DELAY_RST = 16'd2;

    // A table word is {key, char, pattern}.
    localparam int ENTRY_W = 34;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_RESOLVE,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PLAN_READ,
        PLAN_EMPTY,
        PLAN_BUF,
        PLAN_DROP,
        PLAN_PRESS,
        PLAN_DOT
    } plan_t;

    // Default numeric keypad table; slots past the seventeenth read as zero.
    function automatic logic [ENTRY_W-1:0] dflt_entry(input logic [7:0] idx);
        logic [ENTRY_W-1:0] w;
        case (idx)
            8'd0:    w = {10'd28, 8'h64, 16'h0001};
            8'd1:    w = {10'd15, 8'h63, 16'h0002};
            8'd2:    w = {10'd30, 8'h61, 16'h0004};
            8'd3:    w = {10'd48, 8'h62, 16'h0008};
            8'd4:    w = {10'd50, 8'h23, 16'h0010};
            8'd5:    w = {10'd10, 8'h39, 16'h0020};
            8'd6:    w = {10'd4,  8'h33, 16'h0040};
            8'd7:    w = {10'd7,  8'h36, 16'h0080};
            8'd8:    w = {10'd11, 8'h30, 16'h0100};
            8'd9:    w = {10'd9,  8'h38, 16'h0200};
            8'd10:   w = {10'd3,  8'h32, 16'h0400};
            8'd11:   w = {10'd6,  8'h35, 16'h0800};
            8'd12:   w = {10'd8,  8'h37, 16'h2000};
            8'd13:   w = {10'd2,  8'h31, 16'h4000};
            8'd14:   w = {10'd5,  8'h34, 16'h8000};
            8'd15:   w = {10'd14, 8'h41, 16'h1004};
            8'd16:   w = {10'd52, 8'h43, 16'h1002};
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* src/keypad_scan_autorepeat_translate_core.sv */
// Top level of the 4x4 keypad scanner with autorepeat, key translation and
// a character ring buffer. Depends on ksat_pkg.
`default_nettype none

// Keypad scanner core. Each input beat carries a command. A scan tick (command
// 0) carries the four row status bytes; bit 7 of each is flipped, the high
// nibbles are packed with row 0 on top and inverted into a 16-bit key pattern.
// The autorepeat tracker fires on a new nonzero pattern, then once the pattern
// has been held first_delay ticks, then every repeat_delay ticks. A firing
// pattern is looked up in the translation table, lowest matching slot first,
// among the first min(table_count, TABLE_DEPTH) slots. Codes A, B, M and MENU
// push the slot's character into the ring buffer (kind 1, or kind 2 when the
// ring is full and the character is dropped); DOT gives shift-tab as four key
// events; any other nonzero code gives a press and a release. A zero code, a
// zero buffered character, or no match gives no result. A table write
// (command 1) loads one slot and gives no result; a read (command 2) pops one
// byte (kind 3) or reports an empty ring (kind 4); command 3 is ignored.
// The last result beat of each input beat carries tlast.
// Table writes and ignored commands leave the core idle, so it stays ready
// for the next beat. A read passes through the emit state, which waits on
// output stalls. A scan tick goes through the check state back to idle when
// nothing fires; when it fires, the table is walked through its single
// registered read port, one slot per cycle; no match returns to idle, a match
// goes to the resolve state and then, if it gives results, to the emit state.
// The core accepts no beat while a scan or read is in progress. The result
// register lets the next input beat be taken while the previous result still
// waits on the master side.
module keypad_scan_autorepeat_translate_core
    import ksat_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int RING_DEPTH  = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration writes.
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // Slave side. tdata, from bit 0: command[1:0], row0_status[9:2],
    // row1_status[17:10], row2_status[25:18], row3_status[33:26],
    // entry_index[38:34], entry_pattern[54:39], entry_char[62:55],
    // entry_key[72:63], zero fill [79:73].
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,
    // Master side. tdata, from bit 0: event_key[9:0], pressed[10],
    // char_out[18:11], zero fill [23:19]. tuser: kind[2:0].
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 6) ? CW : 6;
    localparam int RW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);

    // Input field extraction.
    logic [1:0]  command;
    logic [7:0]  row0_status, row1_status, row2_status, row3_status;
    logic [4:0]  entry_index;
    logic [15:0] entry_pattern;
    logic [7:0]  entry_char;
    logic [9:0]  entry_key;

    assign command       = s_tdata[1:0];
    assign row0_status   = s_tdata[9:2];
    assign row1_status   = s_tdata[17:10];
    assign row2_status   = s_tdata[25:18];
    assign row3_status   = s_tdata[33:26];
    assign entry_index   = s_tdata[38:34];
    assign entry_pattern = s_tdata[54:39];
    assign entry_char    = s_tdata[62:55];
    assign entry_key     = s_tdata[72:63];

    // Registers.
    state_t             state_reg, state_next;
    plan_t              plan_reg, plan_next;
    logic [1:0]         beat_reg, beat_next;
    logic [5:0]         table_count_reg, table_count_next;
    logic [15:0]        first_delay_reg, first_delay_next;
    logic [15:0]        repeat_delay_reg, repeat_delay_next;
    logic [15:0]        pat_reg, pat_next;
    logic [15:0]        prev_pat_reg, prev_pat_next;
    logic [31:0]        tick_reg, tick_next;
    logic [31:0]        deadline_reg, deadline_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [LW-1:0]      lim_reg, lim_next;
    logic               pend_reg, pend_next;
    logic [ENTRY_W-1:0] hit_reg, hit_next;
    logic [RW-1:0]      head_reg, head_next;
    logic [RW-1:0]      tail_reg, tail_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_kind_reg, out_kind_next;
    logic [9:0]         out_key_reg, out_key_next;
    logic               out_pressed_reg, out_pressed_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;

    // Translation table: memory plus one valid bit per slot; an unwritten
    // slot reads as its default entry.
    logic [ENTRY_W-1:0]     tbl_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] tbl_vld_reg;
    logic [ENTRY_W-1:0]     tbl_rd_reg;
    logic                   tbl_rd_vld_reg;
    logic [TW-1:0]          tbl_rd_idx_reg;
    logic [TW-1:0]          tbl_addr;
    logic                   tbl_we;
    logic [TW-1:0]          tbl_wr_addr;
    logic [ENTRY_W-1:0]     tbl_word;

    // Character ring.
    logic [7:0]  ring_mem [RING_DEPTH];
    logic [7:0]  ring_rd_reg;
    logic        ring_we;
    logic        ring_re;

    // Handshake and shared decode.
    logic        in_accept;
    logic        out_free;
    logic [15:0] scan_pat;
    logic        issue;
    logic        match;
    logic [31:0] tick_diff;
    logic        fire;
    logic [9:0]  hit_key;
    logic [7:0]  hit_char;
    logic        buffered_code;
    logic        ring_has_room;
    logic        ring_not_empty;
    logic        beat_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // Flip bit 7, keep the high nibble, pack row 0 on top and invert.
    assign scan_pat = ~{row0_status[7:4] ^ 4'h8, row1_status[7:4] ^ 4'h8,
                        row2_status[7:4] ^ 4'h8, row3_status[7:4] ^ 4'h8};

    // Table walk: address for slot idx_reg goes out this cycle, the data of
    // the previous slot is compared this cycle.
    assign issue    = (state_reg == ST_SEARCH) && (LW'(idx_reg) < lim_reg);
    assign tbl_addr = issue ? idx_reg[TW-1:0] : '0;
    assign tbl_word = tbl_rd_vld_reg ? tbl_rd_reg : dflt_entry(8'(tbl_rd_idx_reg));
    assign match    = pend_reg && (tbl_word[15:0] == pat_reg);

    assign tbl_we      = in_accept && (command == CMD_WRITE)
                         && (32'(entry_index) < TABLE_DEPTH);
    assign tbl_wr_addr = TW'(entry_index);

    // Deadline reached when the wrapped difference is below 2^31.
    assign tick_diff = tick_reg - deadline_reg;
    assign fire      = (pat_reg != '0) && ((pat_reg != prev_pat_reg) || !tick_diff[31]);

    assign hit_key       = hit_reg[33:24];
    assign hit_char      = hit_reg[23:16];
    assign buffered_code = (hit_key == KC_A) || (hit_key == KC_B)
                           || (hit_key == KC_M) || (hit_key == KC_MENU);
    assign ring_has_room  = (fill_reg < FW'(RING_DEPTH));
    assign ring_not_empty = (fill_reg != '0);

    assign ring_re = in_accept && (command == CMD_READ) && ring_not_empty;
    assign ring_we = (state_reg == ST_RESOLVE) && (hit_key != '0) && buffered_code
                     && (hit_char != '0) && ring_has_room;

    always_comb
    begin
        case (plan_reg)
            PLAN_PRESS: beat_last = (beat_reg == 2'd1);
            PLAN_DOT:   beat_last = (beat_reg == 2'd3);
            default:    beat_last = 1'b1;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == CMD_SCAN)
                    begin
                        state_next = ST_CHECK;
                    end
                    else if (command == CMD_READ)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CHECK:
            begin
                state_next = fire ? ST_SEARCH : ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    state_next = ST_RESOLVE;
                end
                else if (!issue && !pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESOLVE:
            begin
                if ((hit_key == '0) || (buffered_code && (hit_char == '0)))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && beat_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        plan_next         = plan_reg;
        beat_next         = beat_reg;
        table_count_next  = table_count_reg;
        first_delay_next  = first_delay_reg;
        repeat_delay_next = repeat_delay_reg;
        pat_next          = pat_reg;
        prev_pat_next     = prev_pat_reg;
        tick_next         = tick_reg;
        deadline_next     = deadline_reg;
        idx_next          = idx_reg;
        lim_next          = lim_reg;
        pend_next         = 1'b0;
        hit_next          = hit_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        fill_next         = fill_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_kind_next     = out_kind_reg;
        out_key_next      = out_key_reg;
        out_pressed_next  = out_pressed_reg;
        out_char_next     = out_char_reg;
        out_last_next     = out_last_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TABLE_COUNT:  table_count_next  = cfg_wdata[5:0];
                REG_FIRST_DELAY:  first_delay_next  = cfg_wdata;
                REG_REPEAT_DELAY: repeat_delay_next = cfg_wdata;
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                beat_next = 2'd0;
                if (in_accept)
                begin
                    if (command == CMD_SCAN)
                    begin
                        pat_next  = scan_pat;
                        tick_next = tick_reg + 32'd1;
                    end
                    else if (command == CMD_READ)
                    begin
                        if (ring_not_empty)
                        begin
                            plan_next = PLAN_READ;
                            head_next = (head_reg == RW'(RING_DEPTH - 1)) ? '0
                                                                           : head_reg + 1'b1;
                            fill_next = fill_reg - 1'b1;
                        end
                        else
                        begin
                            plan_next = PLAN_EMPTY;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                prev_pat_next = pat_reg;
                idx_next      = '0;
                lim_next      = (32'(table_count_reg) < TABLE_DEPTH) ? LW'(table_count_reg)
                                                                     : LW'(TABLE_DEPTH);
                if (fire)
                begin
                    deadline_next = tick_reg + ((pat_reg != prev_pat_reg)
                                                ? 32'(first_delay_reg)
                                                : 32'(repeat_delay_reg));
                end
            end
            ST_SEARCH:
            begin
                if (issue)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (match)
                begin
                    hit_next = tbl_word;
                end
            end
            ST_RESOLVE:
            begin
                if (buffered_code)
                begin
                    if (ring_has_room)
                    begin
                        plan_next = PLAN_BUF;
                    end
                    else
                    begin
                        plan_next = PLAN_DROP;
                    end
                end
                else if (hit_key == KC_DOT)
                begin
                    plan_next = PLAN_DOT;
                end
                else
                begin
                    plan_next = PLAN_PRESS;
                end
                if (ring_we)
                begin
                    tail_next = (tail_reg == RW'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_last_next    = beat_last;
                    out_kind_next    = KIND_KEY_EVENT;
                    out_key_next     = '0;
                    out_pressed_next = 1'b0;
                    out_char_next    = '0;
                    beat_next        = beat_reg + 1'b1;
                    case (plan_reg)
                        PLAN_READ:
                        begin
                            out_kind_next = KIND_READ_BYTE;
                            out_char_next = ring_rd_reg;
                        end
                        PLAN_EMPTY:
                        begin
                            out_kind_next = KIND_READ_EMPTY;
                        end
                        PLAN_BUF:
                        begin
                            out_kind_next = KIND_CHAR_BUF;
                            out_char_next = hit_char;
                        end
                        PLAN_DROP:
                        begin
                            out_kind_next = KIND_CHAR_DROP;
                            out_char_next = hit_char;
                        end
                        PLAN_PRESS:
                        begin
                            out_key_next     = hit_key;
                            out_pressed_next = (beat_reg == 2'd0);
                        end
                        PLAN_DOT:
                        begin
                            // Shift down, tab down, tab up, shift up.
                            out_key_next     = ((beat_reg == 2'd1) || (beat_reg == 2'd2))
                                               ? KC_TAB : KC_LEFTSHIFT;
                            out_pressed_next = !beat_reg[1];
                        end
                        default:
                        begin
                            out_kind_next = KIND_READ_EMPTY;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            plan_reg         <= PLAN_EMPTY;
            beat_reg         <= '0;
            table_count_reg  <= TABLE_COUNT_RST;
            first_delay_reg  <= FIRST_DELAY_RST;
            repeat_delay_reg <= REPEAT_DELAY_RST;
            prev_pat_reg     <= '0;
            tick_reg         <= '0;
            deadline_reg     <= '0;
            idx_reg          <= '0;
            lim_reg          <= '0;
            pend_reg         <= 1'b0;
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
            out_valid_reg    <= 1'b0;
            tbl_vld_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            plan_reg         <= plan_next;
            beat_reg         <= beat_next;
            table_count_reg  <= table_count_next;
            first_delay_reg  <= first_delay_next;
            repeat_delay_reg <= repeat_delay_next;
            prev_pat_reg     <= prev_pat_next;
            tick_reg         <= tick_next;
            deadline_reg     <= deadline_next;
            idx_reg          <= idx_next;
            lim_reg          <= lim_next;
            pend_reg         <= pend_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            fill_reg         <= fill_next;
            out_valid_reg    <= out_valid_next;
            if (tbl_we)
            begin
                tbl_vld_reg[tbl_wr_addr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pat_reg         <= pat_next;
        hit_reg         <= hit_next;
        out_kind_reg    <= out_kind_next;
        out_key_reg     <= out_key_next;
        out_pressed_reg <= out_pressed_next;
        out_char_reg    <= out_char_next;
        out_last_reg    <= out_last_next;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wr_addr] <= {entry_key, entry_char, entry_pattern};
        end
        tbl_rd_reg     <= tbl_mem[tbl_addr];
        tbl_rd_vld_reg <= tbl_vld_reg[tbl_addr];
        tbl_rd_idx_reg <= tbl_addr;
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[tail_reg] <= hit_char;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[head_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_char_reg, out_pressed_reg, out_key_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* dv/ksat_score_pkg.sv */
`timescale 1ns / 1ps
// Beat and result types plus the scoreboard class for the keypad scanner bench.
// The class predicts results from accepted input beats and checks the output.
// Depends on ksat_pkg for commands, kinds, key codes and register indexes.

package ksat_score_pkg;
    import ksat_pkg::*;

    localparam int TABLE_SLOTS = 32;
    localparam int RING_SLOTS  = 64;

    // The one command value the core ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Laid out exactly as the slave tdata bus, lowest field last.
    typedef struct packed {
        logic [6:0]  zero_fill;
        logic [9:0]  entry_key;
        logic [7:0]  entry_char;
        logic [15:0] entry_pattern;
        logic [4:0]  entry_index;
        logic [7:0]  row3;
        logic [7:0]  row2;
        logic [7:0]  row1;
        logic [7:0]  row0;
        logic [1:0]  command;
    } keypad_beat_t;

    typedef struct {
        logic [2:0] kind;
        logic [9:0] event_key;
        logic       pressed;
        logic [7:0] char_out;
        logic       last;
    } keypad_result_t;

    class keypad_scoreboard;
        logic [15:0]    slot_pattern [TABLE_SLOTS];
        logic [7:0]     slot_char [TABLE_SLOTS];
        logic [9:0]     slot_key [TABLE_SLOTS];
        logic [5:0]     table_count;
        logic [15:0]    first_delay;
        logic [15:0]    repeat_delay;
        logic [15:0]    held_pattern;
        logic [31:0]    repeat_due;
        logic [31:0]    scan_ticks;
        logic [7:0]     char_ring [RING_SLOTS];
        int             ring_rd;
        int             ring_wr;
        int             ring_fill;
        keypad_result_t staged[$];
        keypad_result_t awaited[$];
        int             result_no;
        int             error_count;

        function void reset_state();
            logic [15:0] pats [17] = '{16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010,
                                       16'h0020, 16'h0040, 16'h0080, 16'h0100, 16'h0200,
                                       16'h0400, 16'h0800, 16'h2000, 16'h4000, 16'h8000,
                                       16'h1004, 16'h1002};
            logic [7:0]  chars [17] = '{8'h64, 8'h63, 8'h61, 8'h62, 8'h23, 8'h39, 8'h33,
                                        8'h36, 8'h30, 8'h38, 8'h32, 8'h35, 8'h37, 8'h31,
                                        8'h34, 8'h41, 8'h43};
            logic [9:0]  keys [17] = '{10'd28, 10'd15, 10'd30, 10'd48, 10'd50, 10'd10,
                                       10'd4, 10'd7, 10'd11, 10'd9, 10'd3, 10'd6, 10'd8,
                                       10'd2, 10'd5, 10'd14, 10'd52};
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                slot_pattern[i] = (i < 17) ? pats[i] : 16'h0;
                slot_char[i]    = (i < 17) ? chars[i] : 8'h0;
                slot_key[i]     = (i < 17) ? keys[i] : 10'h0;
            end
            table_count  = TABLE_COUNT_RST;
            first_delay  = FIRST_DELAY_RST;
            repeat_delay = REPEAT_DELAY_RST;
            held_pattern = '0;
            repeat_due   = '0;
            scan_ticks   = '0;
            ring_rd      = 0;
            ring_wr      = 0;
            ring_fill    = 0;
            staged.delete();
            awaited.delete();
            result_no    = 0;
            error_count  = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_TABLE_COUNT:  table_count = value[5:0];
                REG_FIRST_DELAY:  first_delay = value;
                REG_REPEAT_DELAY: repeat_delay = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void stage(logic [2:0] kind, logic [9:0] key, logic pr, logic [7:0] ch);
            keypad_result_t r;
            r.kind      = kind;
            r.event_key = key;
            r.pressed   = pr;
            r.char_out  = ch;
            r.last      = 1'b0;
            staged.push_back(r);
        endfunction

        // Flip bit 7, keep the high nibbles with row 0 on top, then invert.
        function logic [15:0] key_pattern(keypad_beat_t b);
            logic [31:0] rows;
            rows = {b.row0, b.row1, b.row2, b.row3} ^ 32'h8080_8080;
            return ~{rows[31:28], rows[23:20], rows[15:12], rows[7:4]};
        endfunction

        function void predict_scan(keypad_beat_t b);
            logic [15:0] pat;
            logic        fire;
            int          hit;
            int          span;
            logic [9:0]  code;
            logic [7:0]  ch;
            pat = key_pattern(b);
            scan_ticks = scan_ticks + 32'd1;
            fire = 1'b0;
            if (pat != 16'h0)
            begin
                if (pat != held_pattern)
                begin
                    repeat_due = scan_ticks + first_delay;
                    fire = 1'b1;
                end
                else if (32'(scan_ticks - repeat_due) < 32'h8000_0000)
                begin
                    repeat_due = scan_ticks + repeat_delay;
                    fire = 1'b1;
                end
            end
            held_pattern = pat;
            if (!fire)
                return;
            span = (table_count < TABLE_SLOTS) ? int'(table_count) : TABLE_SLOTS;
            hit = -1;
            for (int i = 0; i < span; i++)
                if (hit < 0 && slot_pattern[i] == pat)
                    hit = i;
            if (hit < 0)
                return;
            code = slot_key[hit];
            ch   = slot_char[hit];
            if (code == 10'h0)
                return;
            if (code == KC_A || code == KC_B || code == KC_M || code == KC_MENU)
            begin
                if (ch == 8'h0)
                    return;
                if (ring_fill < RING_SLOTS)
                begin
                    char_ring[ring_wr] = ch;
                    ring_wr = (ring_wr + 1) % RING_SLOTS;
                    ring_fill++;
                    stage(KIND_CHAR_BUF, 10'h0, 1'b0, ch);
                end
                else
                    stage(KIND_CHAR_DROP, 10'h0, 1'b0, ch);
            end
            else if (code == KC_DOT)
            begin
                stage(KIND_KEY_EVENT, KC_LEFTSHIFT, 1'b1, 8'h0);
                stage(KIND_KEY_EVENT, KC_TAB, 1'b1, 8'h0);
                stage(KIND_KEY_EVENT, KC_TAB, 1'b0, 8'h0);
                stage(KIND_KEY_EVENT, KC_LEFTSHIFT, 1'b0, 8'h0);
            end
            else
            begin
                stage(KIND_KEY_EVENT, code, 1'b1, 8'h0);
                stage(KIND_KEY_EVENT, code, 1'b0, 8'h0);
            end
        endfunction

        function void note_beat(keypad_beat_t b);
            staged.delete();
            case (b.command)
                CMD_SCAN: predict_scan(b);
                CMD_WRITE:
                begin
                    slot_pattern[b.entry_index] = b.entry_pattern;
                    slot_char[b.entry_index]    = b.entry_char;
                    slot_key[b.entry_index]     = b.entry_key;
                end
                CMD_READ:
                begin
                    if (ring_fill > 0)
                    begin
                        stage(KIND_READ_BYTE, 10'h0, 1'b0, char_ring[ring_rd]);
                        ring_rd = (ring_rd + 1) % RING_SLOTS;
                        ring_fill--;
                    end
                    else
                        stage(KIND_READ_EMPTY, 10'h0, 1'b0, 8'h0);
                end
                default: ;
            endcase
            if (staged.size() > 0)
                staged[staged.size() - 1].last = 1'b1;
            foreach (staged[i])
                awaited.push_back(staged[i]);
        endfunction

        task report_mismatch(string what);
            $display("ERROR: %s", what);
            error_count++;
        endtask

        task compare_field(string name, logic [9:0] got, logic [9:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d: %s is %0h, %0h expected",
                                          result_no, name, got, want));
        endtask

        task check_result(keypad_result_t got);
            keypad_result_t want;
            result_no++;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("result %0d: kind %0h arrived with none pending",
                                          result_no, got.kind));
                return;
            end
            want = awaited.pop_front();
            compare_field("kind", 10'(got.kind), 10'(want.kind));
            compare_field("event_key", got.event_key, want.event_key);
            compare_field("pressed", 10'(got.pressed), 10'(want.pressed));
            compare_field("char_out", 10'(got.char_out), 10'(want.char_out));
            compare_field("last", 10'(got.last), 10'(want.last));
        endtask
    endclass

endpackage

/* dv/tb_keypad_scan_autorepeat_translate_core.sv */
`timescale 1ns / 1ps
// Self-checking bench for keypad_scan_autorepeat_translate_core: directed and
// random beats with random stalls on both buses, checked against a scoreboard.
// Depends on ksat_pkg and ksat_score_pkg.

module tb_keypad_scan_autorepeat_translate_core;
    import ksat_pkg::*;
    import ksat_score_pkg::*;

    // The longest scan walks 32 slots plus its check and resolve states, so this
    // drain comfortably covers a scan that is still running with no result.
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_ITEMS     = 16;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // command, row0..row3, entry index/pattern/char/key
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // event_key, pressed, char_out
    logic [2:0]  m_tuser;   // kind
    logic        m_tlast;

    keypad_scoreboard sb;

    // Set during a stretch where neither side is allowed to idle.
    bit steady_flow;
    // The stimulus asks for a hold-off by bumping hold_requests; the sink
    // process notices the change and counts the stall out on its own.
    int hold_requests;
    int holds_served;
    int hold_left;
    int cycle_count;

    keypad_scan_autorepeat_translate_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result sink. It idles at random about one cycle in eight, never during
    // the steady stretch, and sits out a full hold-off when one is requested.
    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= steady_flow || ($urandom_range(99) >= 12);
    end

    // Every result beat is checked against the oldest pending expectation.
    always @(posedge clk)
    begin : result_monitor
        keypad_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind      = m_tuser;
            got.event_key = m_tdata[9:0];
            got.pressed   = m_tdata[10];
            got.char_out  = m_tdata[18:11];
            got.last      = m_tlast;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("keypad_scan_autorepeat_translate_core: mismatch");
            $finish;
        end
    end

    // All fields random; callers overwrite what matters for the command.
    function automatic keypad_beat_t random_beat();
        logic [95:0]  r;
        keypad_beat_t b;
        r = {$urandom(), $urandom(), $urandom()};
        b = r[79:0];
        b.zero_fill = '0;
        return b;
    endfunction

    // Row bytes that decode to the given pattern; the low nibbles, which the
    // core drops, stay random.
    function automatic keypad_beat_t scan_beat(logic [15:0] pattern);
        keypad_beat_t b;
        logic [15:0]  acc;
        b = random_beat();
        b.command = CMD_SCAN;
        acc = ~pattern;
        b.row0 = {acc[15:12] ^ 4'h8, b.row0[3:0]};
        b.row1 = {acc[11:8] ^ 4'h8, b.row1[3:0]};
        b.row2 = {acc[7:4] ^ 4'h8, b.row2[3:0]};
        b.row3 = {acc[3:0] ^ 4'h8, b.row3[3:0]};
        return b;
    endfunction

    // Mostly patterns the table knows, so that lookups hit and repeats fire.
    function automatic logic [15:0] pick_pattern();
        case ($urandom_range(3))
            0, 1:    return sb.slot_pattern[$urandom_range(TABLE_SLOTS - 1)];
            2:       return 16'h1 << $urandom_range(15);
            default: return 16'($urandom());
        endcase
    endfunction

    // Offers one beat and returns once it has been accepted. The valid line
    // stays high into the next beat unless the sender decides to idle first.
    task automatic send_beat(keypad_beat_t b);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 12)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(b);
    endtask

    task automatic send_scan(logic [15:0] pattern);
        send_beat(scan_beat(pattern));
    endtask

    task automatic send_rows(logic [7:0] r0, logic [7:0] r1, logic [7:0] r2, logic [7:0] r3);
        keypad_beat_t b;
        b = random_beat();
        b.command = CMD_SCAN;
        b.row0 = r0;
        b.row1 = r1;
        b.row2 = r2;
        b.row3 = r3;
        send_beat(b);
    endtask

    task automatic send_read();
        keypad_beat_t b;
        b = random_beat();
        b.command = CMD_READ;
        send_beat(b);
    endtask

    task automatic send_unused();
        keypad_beat_t b;
        b = random_beat();
        b.command = CMD_UNUSED;
        send_beat(b);
    endtask

    task automatic send_entry(logic [4:0] idx, logic [15:0] pat, logic [7:0] ch,
                              logic [9:0] key);
        keypad_beat_t b;
        b = random_beat();
        b.command       = CMD_WRITE;
        b.entry_index   = idx;
        b.entry_pattern = pat;
        b.entry_char    = ch;
        b.entry_key     = key;
        send_beat(b);
    endtask

    // Stops offering beats and waits until every expected result has come
    // out, then lets any scan that produces nothing run to its end.
    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        wait_quiet();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic set_timing(int count, int first, int again);
        write_register(REG_TABLE_COUNT, 16'(count));
        write_register(REG_FIRST_DELAY, 16'(first));
        write_register(REG_REPEAT_DELAY, 16'(again));
    endtask

    // Random traffic shaped like real use: keys held for a few ticks and then
    // released, reads of the buffer, table edits, plus raw rows and noise.
    // Ignored beats do not count against the item budget.
    task automatic run_phase(int items);
        int          left;
        int          pick;
        int          ticks;
        logic [15:0] pat;
        logic [9:0]  key;
        logic [7:0]  ch;
        left = items;
        while (left > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                pat = pick_pattern();
                ticks = $urandom_range(1, 8);
                repeat (ticks) send_scan(pat);
                left -= ticks;
                if ($urandom_range(1) == 1)
                begin
                    send_scan(16'h0);
                    left--;
                end
            end
            else if (pick < 70)
            begin
                send_read();
                left--;
            end
            else if (pick < 80)
            begin
                case ($urandom_range(6))
                    0:       key = KC_A;
                    1:       key = KC_B;
                    2:       key = KC_M;
                    3:       key = KC_MENU;
                    4:       key = KC_DOT;
                    5:       key = 10'h0;
                    default: key = 10'($urandom_range(767));
                endcase
                case ($urandom_range(3))
                    0, 1:    pat = 16'h1 << $urandom_range(15);
                    2:       pat = (16'h1 << $urandom_range(15)) | (16'h1 << $urandom_range(15));
                    default: pat = 16'($urandom());
                endcase
                ch = ($urandom_range(9) == 0) ? 8'h0 : 8'($urandom());
                send_entry(5'($urandom_range(TABLE_SLOTS - 1)), pat, ch, key);
                left--;
            end
            else if (pick < 93)
            begin
                send_rows(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
                left--;
            end
            else
                send_unused();
        end
    endtask

    initial
    begin
        sb = new;
        sb.reset_state();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_TABLE_COUNT;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        steady_flow   = 1'b0;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;
        cycle_count   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, starting from the reset settings and default table.
        send_scan(16'h0001);        // plain key: press and release
        send_scan(16'h0000);        // all keys up: nothing fires
        send_scan(16'h0004);        // buffered key: character into the ring
        send_scan(16'h1002);        // the DOT key comes out as shift-tab
        send_scan(16'h0002);        // tab key, reached straight from another key
        send_rows(8'h00, 8'h00, 8'h00, 8'h00);  // decodes to a pattern with no slot
        send_rows(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_read();                // pops the buffered character
        send_read();                // ring now empty
        send_unused();
        send_entry(5'd31, 16'hFFFF, 8'hFF, 10'd767);
        send_entry(5'd17, 16'h3000, 8'h00, KC_MENU);   // buffered code with no character
        send_entry(5'd18, 16'h0300, 8'h7A, 10'd0);     // zero key code
        send_entry(5'd19, 16'h0003, 8'h80, KC_B);
        send_entry(5'd20, 16'h0001, 8'h55, 10'd1);     // loses to the lower slot 0
        send_scan(16'hFFFF);        // slot 31 lies beyond the searched count
        set_timing(32, 1, 0);
        send_scan(16'hFFFF);
        send_scan(16'h3000);
        send_scan(16'h0300);
        repeat (3) send_scan(16'h0003);   // first repeat after one tick, then every tick
        send_scan(16'h0001);

        // Hold the DOT key while the sink stalls: four results per tick back
        // the core up until it refuses input, then everything drains.
        set_timing(32, 0, 0);
        hold_requests++;
        repeat (24) send_scan(16'h1002);
        wait_quiet();

        // Overfill the ring with buffered keys, then read it dry and past empty.
        repeat (70)
        begin
            case ($urandom_range(2))
                0:       send_scan(16'h0004);
                1:       send_scan(16'h0008);
                default: send_scan(16'h0010);
            endcase
        end
        repeat (66) send_read();

        // Random phases, each under its own timing and table size.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       set_timing(17, 20, 2);
                1:       set_timing(32, 0, 0);
                2:       set_timing(32, 65535, 65535);
                3:       set_timing(0, 3, 1);
                4:       set_timing(1, 0, 0);
                5:       set_timing(32, 1, 65535);
                6:       set_timing($urandom_range(32), $urandom_range(8), $urandom_range(4));
                default: set_timing(24, 5, 0);
            endcase
            steady_flow = (phase == 7);
            run_phase(PHASE_ITEMS);
        end
        steady_flow = 1'b0;

        wait_quiet();
        if (sb.error_count == 0)
            $display("keypad_scan_autorepeat_translate_core: match");
        else
            $display("keypad_scan_autorepeat_translate_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
src/ksat_pkg.sv
src/keypad_scan_autorepeat_translate_core.sv
dv/ksat_score_pkg.sv
dv/tb_keypad_scan_autorepeat_translate_core.sv
